// ===== rtl/skac_pkg.sv =====
// Shared constants and saturating helpers for the stress kernel accumulator.
// No dependencies; used by skac_arith, skac_fifo and stress_kernel_accumulate_core.
package skac_pkg;

    localparam int CFG_W = 17;
    localparam logic [CFG_W-1:0] CNT_RESET = 17'h10000;

    // Result queue behind the update stage
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    // Working width for clamps (covers a 34x34 trace product)
    localparam int SAT_W = 68;

    // Clamp v to the signed range of an aw-bit accumulator
    function automatic logic signed [63:0] sat_clamp(
        input logic signed [SAT_W-1:0] v,
        input int unsigned             aw
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = (68'sd1 <<< (aw - 1)) - 68'sd1;
        lo = -hi - 68'sd1;
        if (v > hi)
        begin
            sat_clamp = hi[63:0];
        end
        else if (v < lo)
        begin
            sat_clamp = lo[63:0];
        end
        else
        begin
            sat_clamp = v[63:0];
        end
    endfunction

    // Saturating add; both operands already lie in the accumulator range
    function automatic logic signed [63:0] sat_add(
        input logic signed [63:0] a,
        input logic signed [63:0] b,
        input int unsigned        aw
    );
        logic signed [SAT_W-1:0] s;
        s = SAT_W'(a) + SAT_W'(b);
        sat_add = sat_clamp(s, aw);
    endfunction

endpackage

// ===== rtl/skac_mem.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; holds the {bulk, shear} accumulator rows.
module skac_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 96
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] ram [0:DEPTH-1];

    // read returns old data on a same-address write; the core forwards around it
    always_ff @(posedge clk)
    begin
        rdata <= ram[raddr];
        if (we)
        begin
            ram[waddr] <= wdata;
        end
    end

endmodule

// ===== rtl/skac_arith.sv =====
// Increment pipeline: six products, two traces, trace product, saturating sums.
// Depends on skac_pkg. Registers: sample capture, products and traces, trace product, increments.
module skac_arith #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 48
) (
    input  logic                           clk,
    input  logic [12*SAMPLE_WIDTH-1:0]     samples,
    output logic signed [ACC_WIDTH-1:0]    d_shear,
    output logic signed [ACC_WIDTH-1:0]    d_bulk
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = ACC_WIDTH;
    localparam int TW = SW + 2;

    // stage 1: captured samples
    logic signed [SW-1:0] adj_reg [0:5];
    logic signed [SW-1:0] fwd_reg [0:5];

    // stage 2: clamped products, traces
    logic signed [AW-1:0] prod_reg [0:5];
    logic signed [AW-1:0] prod_next [0:5];
    logic signed [TW-1:0] tr_adj_reg;
    logic signed [TW-1:0] tr_fwd_reg;
    logic signed [TW-1:0] tr_adj_next;
    logic signed [TW-1:0] tr_fwd_next;

    // stage 3: trace product, first half of the shear chain
    logic signed [AW-1:0] tprod_reg;
    logic signed [AW-1:0] tprod_next;
    logic signed [AW-1:0] part_reg;
    logic signed [AW-1:0] part_next;
    logic signed [AW-1:0] rest_reg [0:2];

    // stage 4: finished increments
    logic signed [AW-1:0] dsh_reg;
    logic signed [AW-1:0] dsh_next;
    logic signed [AW-1:0] dbk_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            adj_reg[i] <= samples[i*SW +: SW];
            fwd_reg[i] <= samples[(6+i)*SW +: SW];
        end
    end

    always_comb
    begin
        logic signed [2*SW-1:0] p;
        logic signed [63:0]     c;
        for (int i = 0; i < 6; i++)
        begin
            p = adj_reg[i] * fwd_reg[i];
            c = skac_pkg::sat_clamp(skac_pkg::SAT_W'(p), AW);
            prod_next[i] = c[AW-1:0];
        end
        // xx, yy, zz sit at places 0, 3, 5
        tr_adj_next = TW'(adj_reg[0]) + TW'(adj_reg[3]) + TW'(adj_reg[5]);
        tr_fwd_next = TW'(fwd_reg[0]) + TW'(fwd_reg[3]) + TW'(fwd_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        tr_adj_reg <= tr_adj_next;
        tr_fwd_reg <= tr_fwd_next;
    end

    always_comb
    begin
        logic signed [2*TW-1:0] tp;
        logic signed [63:0]     c;
        logic signed [63:0]     s;
        tp = tr_adj_reg * tr_fwd_reg;
        c = skac_pkg::sat_clamp(skac_pkg::SAT_W'(tp), AW);
        tprod_next = c[AW-1:0];
        s = skac_pkg::sat_add(64'(prod_reg[0]), 64'(prod_reg[1]), AW);
        s = skac_pkg::sat_add(s, 64'(prod_reg[2]), AW);
        part_next = s[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        tprod_reg   <= tprod_next;
        part_reg    <= part_next;
        rest_reg[0] <= prod_reg[3];
        rest_reg[1] <= prod_reg[4];
        rest_reg[2] <= prod_reg[5];
    end

    always_comb
    begin
        logic signed [63:0] s;
        s = skac_pkg::sat_add(64'(part_reg), 64'(rest_reg[0]), AW);
        s = skac_pkg::sat_add(s, 64'(rest_reg[1]), AW);
        s = skac_pkg::sat_add(s, 64'(rest_reg[2]), AW);
        dsh_next = s[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        dsh_reg <= dsh_next;
        dbk_reg <= tprod_reg;
    end

    assign d_shear = dsh_reg;
    assign d_bulk  = dbk_reg;

endmodule

// ===== rtl/skac_fifo.sv =====
// Small result queue that decouples the update stage from the output stream.
// Depends on skac_pkg for its depth.
module skac_fifo #(
    parameter int DATA_W = 97
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [DATA_W-1:0]          push_data,
    input  logic                       pop,
    output logic                       out_valid,
    output logic [DATA_W-1:0]          out_data,
    output logic [skac_pkg::FIFO_AW:0] level
);

    localparam int AW = skac_pkg::FIFO_AW;

    logic [DATA_W-1:0] slot [0:skac_pkg::FIFO_DEPTH-1];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       level_reg;
    logic              do_pop;

    assign out_valid = (level_reg != '0);
    assign do_pop    = pop && out_valid;
    assign out_data  = slot[rd_ptr_reg];
    assign level     = level_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            level_reg <= level_reg + (AW+1)'(push) - (AW+1)'(do_pop);
        end
    end

endmodule

// ===== rtl/stress_kernel_accumulate_core.sv =====
// Stress kernel accumulator: per-point shear and bulk cross-correlation sums.
// Throughput: one request per cycle while the result queue has credit. A result passes
//   capture, products, trace product, sum and update, then the result queue, to m_tvalid.
// The accumulator RAM has one read and one write port; read-modify-write hazards
//   are forwarded from the update stage, so repeated points never stall.
// Reset: rst_n clears control; a clearing pass then zeroes all POINTS rows, one
//   per cycle, with s_tready low. point_count resets to 65536.
module stress_kernel_accumulate_core #(
    parameter  int POINTS       = 65536,
    parameter  int SAMPLE_WIDTH = 16,
    parameter  int ACC_WIDTH    = 48,
    localparam int IN_W         = ((12 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W        = ((2 * ACC_WIDTH + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // adj_xx, adj_xy, adj_xz, adj_yy, adj_yz, adj_zz,
    // fwd_xx, fwd_xy, fwd_xz, fwd_yy, fwd_yz, fwd_zz (SAMPLE_WIDTH each)
    input  logic [IN_W-1:0]            s_tdata,
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // shear_sum, bulk_sum (ACC_WIDTH each), zero padded
    output logic [OUT_W-1:0]           m_tdata,
    output logic                       m_tlast,   // pass_end
    // point_count register
    input  logic                       cfg_we,
    input  logic [skac_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int AW     = ACC_WIDTH;
    localparam int IDX_W  = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CW     = (IDX_W + 1 > skac_pkg::CFG_W) ? IDX_W + 1 : skac_pkg::CFG_W;
    localparam int ROW_W  = 2 * AW;
    localparam int Q_W    = ROW_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

    // sequencer codes
    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    logic                       state_reg;
    logic                       state_next;
    logic [IDX_W-1:0]           clr_addr_reg;
    logic [skac_pkg::CFG_W-1:0] count_reg;
    logic [IDX_W-1:0]           point_reg;
    logic [IDX_W-1:0]           point_next;
    logic                       accept;
    logic                       is_last;

    // request tags through the four pipeline stages
    logic [3:0]       vld_reg;
    logic [IDX_W-1:0] idx_reg  [0:3];
    logic [3:0]       last_reg;
    // prior accumulator row for stages 2..4 (stage 1 comes from the RAM)
    logic [ROW_W-1:0] old_reg  [1:3];
    logic [ROW_W-1:0] old_next [1:3];
    logic             fwd1_reg;
    logic [ROW_W-1:0] fwdrow1_reg;
    logic [ROW_W-1:0] old1;

    logic [ROW_W-1:0] ram_rdata;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;

    logic signed [AW-1:0] d_shear;
    logic signed [AW-1:0] d_bulk;
    logic signed [AW-1:0] new_shear;
    logic signed [AW-1:0] new_bulk;
    logic [ROW_W-1:0]     new_row;

    logic [skac_pkg::FIFO_AW:0] q_level;
    logic [Q_W-1:0]             q_data;
    logic [skac_pkg::FIFO_AW:0] inflight;

    // ---------------------------------------------------------------
    // Intake: credit against the result queue covers every request in flight
    // ---------------------------------------------------------------
    assign inflight = (skac_pkg::FIFO_AW+1)'(vld_reg[0]) + (skac_pkg::FIFO_AW+1)'(vld_reg[1])
                    + (skac_pkg::FIFO_AW+1)'(vld_reg[2]) + (skac_pkg::FIFO_AW+1)'(vld_reg[3]);
    assign s_tready = (state_reg == ST_RUN)
                   && ((CW'(q_level) + CW'(inflight)) < CW'(skac_pkg::FIFO_DEPTH));
    assign accept   = s_tvalid && s_tready;

    // last of pass: index reached the clamped count; count 0 acts as 1,
    // counts above POINTS stop at the top row
    assign is_last    = ((CW'(point_reg) + CW'(1)) >= CW'(count_reg)) || (point_reg == LAST_IDX);
    assign point_next = is_last ? '0 : point_reg + IDX_W'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_IDX)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= skac_pkg::CNT_RESET;
            point_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (accept)
            begin
                point_reg <= point_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // Accumulator RAM: row = {bulk, shear}; read issued at accept
    // ---------------------------------------------------------------
    assign ram_we    = (state_reg == ST_CLEAR) || vld_reg[3];
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx_reg[3];
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : new_row;

    skac_mem #(
        .DEPTH  (POINTS),
        .ADDR_W (IDX_W),
        .DATA_W (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (point_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Increment pipeline, aligned with the tag stages
    // ---------------------------------------------------------------
    skac_arith #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_arith (
        .clk     (clk),
        .samples (s_tdata[12*SAMPLE_WIDTH-1:0]),
        .d_shear (d_shear),
        .d_bulk  (d_bulk)
    );

    // ---------------------------------------------------------------
    // Forwarding: the row written by the update stage replaces any stale
    // copy held for the same point further up the pipe. A read that met a
    // write to its own row at the accept edge takes the written row instead.
    // ---------------------------------------------------------------
    assign old1 = fwd1_reg ? fwdrow1_reg : ram_rdata;

    always_comb
    begin
        old_next[1] = old1;
        old_next[2] = old_reg[1];
        old_next[3] = old_reg[2];
        for (int k = 1; k <= 3; k++)
        begin
            if (vld_reg[3] && (idx_reg[3] == idx_reg[k-1]))
            begin
                old_next[k] = new_row;
            end
        end
    end

    // update stage: add increments to the prior row with saturation
    always_comb
    begin
        logic signed [63:0] s;
        logic signed [63:0] b;
        s = skac_pkg::sat_add(64'(signed'(old_reg[3][AW-1:0])), 64'(d_shear), AW);
        b = skac_pkg::sat_add(64'(signed'(old_reg[3][ROW_W-1:AW])), 64'(d_bulk), AW);
        new_shear = s[AW-1:0];
        new_bulk  = b[AW-1:0];
    end

    assign new_row = {new_bulk, new_shear};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg[0]  <= point_reg;
        last_reg[0] <= is_last;
        for (int k = 1; k <= 3; k++)
        begin
            idx_reg[k]  <= idx_reg[k-1];
            last_reg[k] <= last_reg[k-1];
            old_reg[k]  <= old_next[k];
        end
        fwd1_reg    <= vld_reg[3] && (idx_reg[3] == point_reg);
        fwdrow1_reg <= new_row;
    end

    // ---------------------------------------------------------------
    // Result queue and output stream
    // ---------------------------------------------------------------
    skac_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (vld_reg[3]),
        .push_data ({last_reg[3], new_row}),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (q_data),
        .level     (q_level)
    );

    assign m_tdata = OUT_W'(q_data[ROW_W-1:0]);
    assign m_tlast = q_data[ROW_W];

endmodule

// ===== test/stress_kernel_accumulate_core_test.sv =====
// Self-checking testbench for stress_kernel_accumulate_core: random stream traffic,
// point_count sweeps and an alternating-extremes run, checked against an in-bench predictor.
// Depends on rtl/skac_pkg.sv and rtl/stress_kernel_accumulate_core.sv.
module stress_kernel_accumulate_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     POINTS = 65536;
    localparam int     ACC_W  = 48;
    localparam int     IN_W   = 192;
    localparam int     OUT_W  = 96;
    localparam longint ACC_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam longint ACC_LO = -ACC_HI - 64'sd1;

    // Sample corners, Q1.15
    localparam logic [15:0] Q_MAX  = 16'h7FFF;
    localparam logic [15:0] Q_MIN  = 16'h8000;
    localparam logic [15:0] Q_ZERO = 16'h0000;
    localparam logic [15:0] Q_ONE  = 16'h0001;
    localparam logic [15:0] Q_NEG1 = 16'hFFFF;

    // Highest value the 17-bit count register takes; clamps to POINTS
    localparam logic [skac_pkg::CFG_W-1:0] COUNT_ALL_ONES = '1;

    // One expected result, plus the point it belongs to for diagnostics
    typedef struct {
        logic [ACC_W-1:0] shear;
        logic [ACC_W-1:0] bulk;
        logic             pass_end;
        int               point;
    } kernel_sum_t;

    // Tracks per-point accumulators and the point counter, and checks results in order
    class kernel_scoreboard;
        kernel_sum_t                 pending_sums[$];
        longint                      shear_acc[int];
        longint                      bulk_acc[int];
        logic [skac_pkg::CFG_W-1:0]  count_reg = skac_pkg::CNT_RESET;
        int                          next_point = 0;
        int                          fail_count = 0;
        int                          checked = 0;
        int                          requests = 0;
        int                          pass_ends = 0;
        int                          saturated = 0;

        function longint clamp_acc(longint v);
            if (v > ACC_HI)
            begin
                return ACC_HI;
            end
            if (v < ACC_LO)
            begin
                return ACC_LO;
            end
            return v;
        endfunction

        function int pending();
            return pending_sums.size();
        endfunction

        function void set_point_count(logic [skac_pkg::CFG_W-1:0] v);
            count_reg = v;
        endfunction

        // Accepted request: form both increments, update the selected point
        function void note_request(logic [IN_W-1:0] w);
            logic signed [15:0] s;
            longint             adj[6];
            longint             fwd[6];
            longint             d_shear;
            longint             d_bulk;
            longint             tr_adj;
            longint             tr_fwd;
            longint             shear_now;
            longint             bulk_now;
            int unsigned        lim;
            int                 idx;
            int                 i;
            kernel_sum_t        e;

            d_shear = 0;
            for (i = 0; i < 6; i++)
            begin
                s = w[16*i +: 16];
                adj[i] = s;
                s = w[16*(6+i) +: 16];
                fwd[i] = s;
                d_shear = clamp_acc(d_shear + clamp_acc(adj[i] * fwd[i]));
            end
            // traces: xx, yy, zz sit at component 0, 3, 5
            tr_adj = clamp_acc(clamp_acc(adj[0] + adj[3]) + adj[5]);
            tr_fwd = clamp_acc(clamp_acc(fwd[0] + fwd[3]) + fwd[5]);
            d_bulk = clamp_acc(tr_adj * tr_fwd);

            lim = count_reg;
            if (lim < 1)
            begin
                lim = 1;
            end
            if (lim > POINTS)
            begin
                lim = POINTS;
            end
            idx = next_point;

            shear_now = clamp_acc((shear_acc.exists(idx) ? shear_acc[idx] : 0) + d_shear);
            bulk_now  = clamp_acc((bulk_acc.exists(idx) ? bulk_acc[idx] : 0) + d_bulk);
            shear_acc[idx] = shear_now;
            bulk_acc[idx]  = bulk_now;

            // an index at or past the count (count lowered mid-pass) also ends the pass
            e.pass_end = (idx + 1 >= lim);
            next_point = e.pass_end ? 0 : idx + 1;
            e.shear    = shear_now[ACC_W-1:0];
            e.bulk     = bulk_now[ACC_W-1:0];
            e.point    = idx;
            if (shear_now == ACC_HI || shear_now == ACC_LO ||
                bulk_now == ACC_HI || bulk_now == ACC_LO)
            begin
                saturated++;
            end
            requests++;
            pending_sums.push_back(e);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            fail_count++;
        endtask

        task check_result(logic [OUT_W-1:0] d, logic last);
            kernel_sum_t e;
            if (pending_sums.size() == 0)
            begin
                report($sformatf("result with nothing outstanding, data %h", d));
                return;
            end
            e = pending_sums.pop_front();
            if (d[ACC_W-1:0] !== e.shear)
            begin
                report($sformatf("point %0d shear_sum %h, predicted %h",
                                 e.point, d[ACC_W-1:0], e.shear));
            end
            if (d[2*ACC_W-1:ACC_W] !== e.bulk)
            begin
                report($sformatf("point %0d bulk_sum %h, predicted %h",
                                 e.point, d[2*ACC_W-1:ACC_W], e.bulk));
            end
            if (last !== e.pass_end)
            begin
                report($sformatf("point %0d pass_end %b, predicted %b",
                                 e.point, last, e.pass_end));
            end
            if (e.pass_end)
            begin
                pass_ends++;
            end
            checked++;
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_W-1:0]            s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_W-1:0]           m_tdata;
    logic                       m_tlast;
    logic                       cfg_we;
    logic [skac_pkg::CFG_W-1:0] cfg_wdata;

    kernel_scoreboard board = new();

    // Receiver behavior, steered from the main sequence
    bit sink_steady = 1'b0;
    int hold_off_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stress_kernel_accumulate_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Monitor: register writes and accepted requests feed the predictor,
    // accepted results are checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                board.set_point_count(cfg_wdata);
            end
            if (s_tvalid && s_tready)
            begin
                board.note_request(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                board.check_result(m_tdata, m_tlast);
            end
        end
    end

    // Stall lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, a steady mode, and an on-demand long hold-off
    initial
    begin
        int span;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                span = hold_off_cycles;
                m_tready <= 1'b0;
                repeat (span) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (sink_steady)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                span = pick_gap();
                if (span > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // All six adjoint components set to a, all six forward components to f
    function automatic logic [IN_W-1:0] uniform_point(logic [15:0] a, logic [15:0] f);
        return {{6{f}}, {6{a}}};
    endfunction

    function automatic logic [15:0] pick_sample(int style);
        if (style < 4)
        begin
            return 16'($urandom);
        end
        if (style < 7)
        begin
            case ($urandom_range(0, 5))
                0:       return Q_MIN;
                1:       return Q_MAX;
                2:       return Q_NEG1;
                3:       return Q_ZERO;
                4:       return Q_ONE;
                default: return Q_MIN + Q_ONE;
            endcase
        end
        return 16'($urandom_range(0, 63)) - 16'd32;
    endfunction

    // Whole request with one value style: raw bits, corners, or small values
    function automatic logic [IN_W-1:0] random_point();
        logic [IN_W-1:0] w;
        int              style;
        int              i;
        style = $urandom_range(0, 9);
        for (i = 0; i < 12; i++)
        begin
            w[16*i +: 16] = pick_sample(style);
        end
        return w;
    endfunction

    // Offer one request; optionally idle first, or wait until nothing is outstanding
    task automatic send_point(input logic [IN_W-1:0] w, input int gap, input bit wait_empty);
        if (gap > 0 || wait_empty)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (wait_empty)
            begin
                do @(posedge clk); while (board.pending() != 0);
            end
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop offering, let every result come back, then cover the pipeline depth
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_count(input logic [skac_pkg::CFG_W-1:0] v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int                         ph;
        int                         n;
        int                         gap;
        logic [skac_pkg::CFG_W-1:0] lim;

        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The block zeroes its stores after reset with s_tready low
        do @(posedge clk); while (!s_tready);

        // Directed: sample extremes at the reset count (points 0..5)
        send_point(uniform_point(Q_ZERO, Q_ZERO), 0, 1'b0);
        send_point(uniform_point(Q_MAX, Q_MAX), 0, 1'b0);
        send_point(uniform_point(Q_MIN, Q_MIN), 0, 1'b0);
        send_point(uniform_point(Q_MIN, Q_MAX), 0, 1'b0);
        send_point(uniform_point(Q_MAX, Q_MIN), 0, 1'b0);
        send_point(uniform_point(Q_NEG1, Q_ONE), 0, 1'b0);
        drain();

        // Count of zero acts as one; the index is already past it, so the
        // next request still lands on its point, ends the pass and wraps
        write_count('0);
        send_point(uniform_point(16'h1234, 16'h0F0F), 0, 1'b0);
        send_point(uniform_point(16'hC001, 16'h3FFF), 1, 1'b0);
        send_point(uniform_point(Q_MAX, Q_NEG1), 0, 1'b0);
        drain();

        // All-ones count clamps to the number of points
        write_count(COUNT_ALL_ONES);
        send_point(uniform_point(16'h5555, 16'hAAAA), 0, 1'b0);
        send_point(uniform_point(16'hAAAA, 16'h5555), 0, 1'b0);
        send_point(uniform_point(Q_ONE, Q_MIN), 0, 1'b0);
        drain();

        // Lower the count below the current index (3), then wrap at two
        write_count(skac_pkg::CFG_W'(2));
        send_point(uniform_point(16'h0100, 16'hFF00), 0, 1'b0);
        send_point(uniform_point(16'h7000, 16'h0007), 0, 1'b0);
        send_point(uniform_point(Q_MIN, Q_NEG1), 2, 1'b0);
        drain();

        // Random phases, each with its own count and traffic shape:
        // phase 4 runs both sides flat out, phase 5 holds the receiver off
        // so the block backs up, phase 6 lets the sender pause mid-stream
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       lim = skac_pkg::CFG_W'(1);
                1:       lim = skac_pkg::CNT_RESET;
                2:       lim = skac_pkg::CFG_W'($urandom_range(POINTS + 1, 131071));
                3:       lim = skac_pkg::CFG_W'($urandom_range(25, 90));
                default: lim = skac_pkg::CFG_W'($urandom_range(2, 24));
            endcase
            write_count(lim);
            sink_steady = (ph == 4);
            if (ph == 5)
            begin
                hold_off_cycles = 400;
            end
            for (n = 0; n < 90; n++)
            begin
                gap = (ph == 4 || ph == 5) ? 0 : pick_gap();
                send_point(random_point(), gap, (ph == 6 && n == 50));
            end
            drain();
        end

        // Two points alternating between opposite extremes, both sides flat out
        write_count(skac_pkg::CFG_W'(2));
        sink_steady = 1'b1;
        for (n = 0; n < 20; n++)
        begin
            send_point(uniform_point(Q_MIN, Q_MIN), 0, 1'b0);
            send_point(uniform_point(Q_MIN, Q_MAX), 0, 1'b0);
        end
        for (n = 0; n < 4; n++)
        begin
            send_point(uniform_point(Q_MIN, Q_MAX), 0, 1'b0);
            send_point(uniform_point(Q_MIN, Q_MIN), 0, 1'b0);
        end
        sink_steady = 1'b0;
        drain();

        $display("run: %0d requests, %0d results checked, %0d pass ends",
                 board.requests, board.checked, board.pass_ends);
        $display("run: counts 0..all-ones swept, %0d results at an accumulator limit",
                 board.saturated);
        if (board.fail_count == 0)
        begin
            $display("stress_kernel_accumulate_core_test: PASS");
        end
        else
        begin
            $display("stress_kernel_accumulate_core_test: FAIL");
        end
        $finish;
    end

    // Watchdog, well beyond the clearing pass plus the slowest legal traffic
    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", board.pending());
        $display("stress_kernel_accumulate_core_test: FAIL");
        $finish;
    end

endmodule
